// File: hdl/assert_macros.svh
// Assertion helpers used by the checker file (ipc_checker.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/ipc_pkg.sv
`default_nettype none

package ipc_pkg;

  localparam int WINDOW_DEF = 15;
  localparam int SAMPLE_W   = 10;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int TIMER_W    = 16;
  localparam int OP_W       = 2;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int REG_IDX_W  = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_START  = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP   = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_DRY      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WET      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_RUN  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_RUN  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COOLDOWN = 3'd4;

  // register reset values
  localparam logic [SAMPLE_W-1:0] DRY_RST      = 10'd450;
  localparam logic [SAMPLE_W-1:0] WET_RST      = 10'd520;
  localparam logic [TIMER_W-1:0]  MIN_RUN_RST  = 16'd100;
  localparam logic [TIMER_W-1:0]  MAX_RUN_RST  = 16'd600;
  localparam logic [TIMER_W-1:0]  COOLDOWN_RST = 16'd300;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_WATERING = 2'd1,
    MODE_COOLDOWN = 2'd2
  } mode_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] dry_threshold;
    logic [SAMPLE_W-1:0] wet_threshold;
    logic [TIMER_W-1:0]  min_run_ticks;
    logic [TIMER_W-1:0]  max_run_ticks;
    logic [TIMER_W-1:0]  cooldown_ticks;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the input transfer
    logic sample;    // ring/sum update, divider load
    logic div_step;  // one quotient bit
    logic step;      // mode machine step
    logic emit;      // load the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic new_is_sample;  // incoming operation is a sample tick
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: hdl/ipc_cfg.sv
`default_nettype none

module ipc_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ipc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ipc_pkg::DATA_W-1:0] pwdata,
  output logic      [ipc_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output ipc_pkg::cfg_t                   cfg_o
);

  ipc_pkg::cfg_t cfg_q, cfg_d;
  logic [ipc_pkg::REG_IDX_W-1:0] idx;
  logic wr_en;

  assign idx    = paddr[ipc_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        ipc_pkg::REG_DRY:      cfg_d.dry_threshold  = pwdata[ipc_pkg::SAMPLE_W-1:0];
        ipc_pkg::REG_WET:      cfg_d.wet_threshold  = pwdata[ipc_pkg::SAMPLE_W-1:0];
        ipc_pkg::REG_MIN_RUN:  cfg_d.min_run_ticks  = pwdata[ipc_pkg::TIMER_W-1:0];
        ipc_pkg::REG_MAX_RUN:  cfg_d.max_run_ticks  = pwdata[ipc_pkg::TIMER_W-1:0];
        ipc_pkg::REG_COOLDOWN: cfg_d.cooldown_ticks = pwdata[ipc_pkg::TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ipc_pkg::REG_DRY:      prdata = ipc_pkg::DATA_W'(cfg_q.dry_threshold);
      ipc_pkg::REG_WET:      prdata = ipc_pkg::DATA_W'(cfg_q.wet_threshold);
      ipc_pkg::REG_MIN_RUN:  prdata = ipc_pkg::DATA_W'(cfg_q.min_run_ticks);
      ipc_pkg::REG_MAX_RUN:  prdata = ipc_pkg::DATA_W'(cfg_q.max_run_ticks);
      ipc_pkg::REG_COOLDOWN: prdata = ipc_pkg::DATA_W'(cfg_q.cooldown_ticks);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dry_threshold  <= ipc_pkg::DRY_RST;
      cfg_q.wet_threshold  <= ipc_pkg::WET_RST;
      cfg_q.min_run_ticks  <= ipc_pkg::MIN_RUN_RST;
      cfg_q.max_run_ticks  <= ipc_pkg::MAX_RUN_RST;
      cfg_q.cooldown_ticks <= ipc_pkg::COOLDOWN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ipc_ctrl.sv
`default_nettype none

module ipc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire ipc_pkg::stat_t stat_i,
  output ipc_pkg::cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_READY,
    ST_SAMPLE,
    ST_DIVIDE,
    ST_STEP,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_READY);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_READY: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.new_is_sample ? ST_SAMPLE : ST_STEP;
        end
      end
      ST_SAMPLE: begin
        cmd_o.sample = 1'b1;
        state_d      = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (stat_i.div_done) begin
          state_d = ST_STEP;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_READY;
        end
      end
      default: state_d = ST_READY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_READY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ipc_datapath.sv
`default_nettype none

module ipc_datapath #(
  parameter int WINDOW = ipc_pkg::WINDOW_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ipc_pkg::cmd_t                cmd_i,
  output ipc_pkg::stat_t                    stat_o,
  input  wire ipc_pkg::cfg_t                cfg_i,
  input  wire logic [ipc_pkg::OP_W-1:0]     operation_i,
  input  wire logic [ipc_pkg::SAMPLE_W-1:0] soil_sample_i,
  input  wire logic                         tank_water_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              pump_on_o,
  output logic      [1:0]                   mode_o,
  output logic      [ipc_pkg::SAMPLE_W-1:0] moisture_average_o,
  output logic                              start_refused_o
);

  localparam int SW     = ipc_pkg::SAMPLE_W;
  localparam int TW     = ipc_pkg::TIMER_W;
  localparam int SUM_W  = $clog2(ipc_pkg::SAMPLE_MAX * WINDOW + 1);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(SUM_W + 1);

  // captured item
  logic [ipc_pkg::OP_W-1:0] op_q;
  logic [SW-1:0]            sample_q;
  logic                     water_q;

  // averaging state
  logic [SW-1:0]     ring_q [WINDOW];
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [SUM_W-1:0]  sum_q, sum_d, drop;
  logic              full;

  // divider
  logic [SUM_W-1:0]  quo_q;
  logic [FILL_W-1:0] rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [FILL_W:0]   trial;
  logic              fits;

  // mode machine
  ipc_pkg::mode_e mode_q, mode_d;
  logic [TW-1:0]  timer_q, timer_d, timer_inc;
  logic [SW-1:0]  avg_q, avg_new;
  logic           refused_q, refused_d;

  logic out_valid_q;

  assign full = (fill_q == FILL_W'(WINDOW));
  assign drop = full ? SUM_W'(ring_q[slot_q]) : '0;
  assign sum_d = sum_q - drop + SUM_W'(sample_q);
  assign fill_d = full ? fill_q : fill_q + 1'b1;
  assign slot_d = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = (trial >= {1'b0, fill_q});

  assign stat_o.new_is_sample = (operation_i == ipc_pkg::OP_SAMPLE);
  assign stat_o.div_done      = (cnt_q == CNT_W'(SUM_W));
  assign stat_o.out_free      = !out_valid_q || !out_stall_i;

  assign timer_inc = (timer_q == '1) ? timer_q : timer_q + 1'b1;

  always_comb begin
    mode_d    = mode_q;
    timer_d   = timer_q;
    avg_new   = avg_q;
    refused_d = 1'b0;
    unique case (op_q)
      ipc_pkg::OP_SAMPLE: begin
        avg_new = quo_q[SW-1:0];
        timer_d = timer_inc;
        unique case (mode_q)
          ipc_pkg::MODE_IDLE: begin
            if (avg_new <= cfg_i.dry_threshold && water_q) begin
              mode_d  = ipc_pkg::MODE_WATERING;
              timer_d = '0;
            end
          end
          ipc_pkg::MODE_WATERING: begin
            if (!water_q || timer_inc >= cfg_i.max_run_ticks ||
                (avg_new >= cfg_i.wet_threshold && timer_inc >= cfg_i.min_run_ticks)) begin
              mode_d  = ipc_pkg::MODE_COOLDOWN;
              timer_d = '0;
            end
          end
          ipc_pkg::MODE_COOLDOWN: begin
            if (timer_inc >= cfg_i.cooldown_ticks) begin
              mode_d  = ipc_pkg::MODE_IDLE;
              timer_d = '0;
            end
          end
          default: begin
            mode_d  = ipc_pkg::MODE_IDLE;
            timer_d = '0;
          end
        endcase
      end
      ipc_pkg::OP_START: begin
        if (mode_q == ipc_pkg::MODE_IDLE && water_q) begin
          mode_d  = ipc_pkg::MODE_WATERING;
          timer_d = '0;
        end else begin
          refused_d = 1'b1;
        end
      end
      ipc_pkg::OP_STOP: begin
        mode_d  = ipc_pkg::MODE_COOLDOWN;
        timer_d = '0;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      mode_q      <= ipc_pkg::MODE_IDLE;
      timer_q     <= '0;
      avg_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.sample) begin
        slot_q <= slot_d;
        fill_q <= fill_d;
        sum_q  <= sum_d;
        cnt_q  <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.step) begin
        mode_q  <= mode_d;
        timer_q <= timer_d;
        avg_q   <= avg_new;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= operation_i;
      sample_q <= soil_sample_i;
      water_q  <= tank_water_i;
    end
    if (cmd_i.sample) begin
      ring_q[slot_q] <= sample_q;
      quo_q          <= sum_d;
      rem_q          <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[SUM_W-2:0], fits};
      rem_q <= fits ? FILL_W'(trial - {1'b0, fill_q}) : trial[FILL_W-1:0];
    end
    if (cmd_i.step) begin
      refused_q <= refused_d;
    end
    if (cmd_i.emit) begin
      pump_on_o          <= (mode_q == ipc_pkg::MODE_WATERING);
      mode_o             <= mode_q;
      moisture_average_o <= avg_q;
      start_refused_o    <= refused_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: hdl/irrigation_pump_controller.sv
// Irrigation pump controller.
// Input channel (in_valid_i / in_stall_o): one transfer per event, carrying
//   operation_i (sample tick, manual start, manual stop), soil_sample_i and
//   tank_water_i. A transfer happens when valid is high and stall is low.
// Output channel (out_valid_o / out_stall_i): exactly one result per input
//   transfer: pump_on_o, mode_o, moisture_average_o, start_refused_o.
// Sequencing: a sample tick goes through capture, ring update, the
//   bit-serial divider forming the moving average (one quotient bit per
//   cycle), mode step and emit; other operations skip the ring update and
//   the divider. One item is processed at a time; the next input transfer
//   is taken the cycle after the result is loaded into the output register.
// Stall: the result waits in the output register; a new item is taken and
//   processed meanwhile, and it holds in its last step until the register
//   frees up.
// Reset (rst_ni, async low): mode idle, timer, averages and fill count zero,
//   thresholds and times back to their defaults. The sample ring is not
//   cleared; entries are read only after the window has filled.
// Config: APB registers at byte addresses 0,4,8,12,16 (dry, wet, min run,
//   max run, cooldown); write only while no item is in flight.
`default_nettype none

module irrigation_pump_controller #(
  parameter int WINDOW = ipc_pkg::WINDOW_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // config port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ipc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [ipc_pkg::DATA_W-1:0]   pwdata,
  output logic      [ipc_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  // input channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [ipc_pkg::OP_W-1:0]     operation_i,
  input  wire logic [ipc_pkg::SAMPLE_W-1:0] soil_sample_i,
  input  wire logic                         tank_water_i,
  // output channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              pump_on_o,
  output logic      [1:0]                   mode_o,
  output logic      [ipc_pkg::SAMPLE_W-1:0] moisture_average_o,
  output logic                              start_refused_o
);

  ipc_pkg::cfg_t  cfg;
  ipc_pkg::cmd_t  cmd;
  ipc_pkg::stat_t stat;

  ipc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencing: capture, ring update, divide, mode step, emit (other operations skip ring update and divide)
  ipc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ipc_datapath #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_i              (cfg),
    .operation_i        (operation_i),
    .soil_sample_i      (soil_sample_i),
    .tank_water_i       (tank_water_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .pump_on_o          (pump_on_o),
    .mode_o             (mode_o),
    .moisture_average_o (moisture_average_o),
    .start_refused_o    (start_refused_o)
  );

endmodule

`default_nettype wire

// File: hdl/ipc_checker.sv
`default_nettype none
`include "assert_macros.svh"

module ipc_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic                         pump_on_o,
  input wire logic [1:0]                   mode_o,
  input wire logic [ipc_pkg::SAMPLE_W-1:0] moisture_average_o,
  input wire logic                         start_refused_o
);

  // pump drive follows the reported mode
  `ASSERT_IMPL(a_pump_mode, clk_i, rst_ni, out_valid_o,
               pump_on_o == (mode_o == ipc_pkg::MODE_WATERING))

  // one item in flight: busy right after an input transfer
  `ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
               out_valid_o && $stable(mode_o) && $stable(moisture_average_o) &&
               $stable(start_refused_o) && $stable(pump_on_o))

endmodule

bind irrigation_pump_controller ipc_checker u_ipc_checker (.*);

`default_nettype wire

// File: tb/irrigation_pump_controller_tb.sv
`default_nettype none

module irrigation_pump_controller_tb;

  // unused operation code: the block must answer it without touching state
  localparam logic [ipc_pkg::OP_W-1:0]      OP_UNUSED   = 2'd3;
  // register slot past the last one, writes there are dropped
  localparam logic [ipc_pkg::REG_IDX_W-1:0] REG_UNUSED  = 3'd7;
  // cycles without any transfer before the run is declared hung
  localparam int                            QUIET_LIMIT = 3000;
  // length of the long receiver hold-off that backs the block up
  localparam int                            HOLD_CYCLES = 400;
  localparam int                            PHASES      = 8;
  localparam int                            PHASE_ITEMS = 112;

  typedef struct packed {
    logic                         pump_on;
    ipc_pkg::mode_e               mode;
    logic [ipc_pkg::SAMPLE_W-1:0] avg;
    logic                         refused;
  } pump_status_t;

  // Tracks thresholds, moving average and mode machine; one expected status
  // per accepted event, checked in order.
  class pump_mode_tracker;
    logic [ipc_pkg::SAMPLE_W-1:0] dry;
    logic [ipc_pkg::SAMPLE_W-1:0] wet;
    logic [ipc_pkg::TIMER_W-1:0]  min_run;
    logic [ipc_pkg::TIMER_W-1:0]  max_run;
    logic [ipc_pkg::TIMER_W-1:0]  cool;
    logic [ipc_pkg::SAMPLE_W-1:0] ring [ipc_pkg::WINDOW_DEF];
    int unsigned                  slot;
    int unsigned                  fill;
    int unsigned                  sum;
    ipc_pkg::mode_e               cur;
    logic [ipc_pkg::TIMER_W-1:0]  timer;
    logic [ipc_pkg::SAMPLE_W-1:0] avg;
    pump_status_t                 expected_status [$];

    function new();
      dry     = ipc_pkg::DRY_RST;
      wet     = ipc_pkg::WET_RST;
      min_run = ipc_pkg::MIN_RUN_RST;
      max_run = ipc_pkg::MAX_RUN_RST;
      cool    = ipc_pkg::COOLDOWN_RST;
      foreach (ring[i]) ring[i] = '0;
      slot  = 0;
      fill  = 0;
      sum   = 0;
      cur   = ipc_pkg::MODE_IDLE;
      timer = '0;
      avg   = '0;
    endfunction

    function void write_reg(input logic [ipc_pkg::REG_IDX_W-1:0] idx,
                            input logic [ipc_pkg::DATA_W-1:0] val);
      case (idx)
        ipc_pkg::REG_DRY:      dry     = val[ipc_pkg::SAMPLE_W-1:0];
        ipc_pkg::REG_WET:      wet     = val[ipc_pkg::SAMPLE_W-1:0];
        ipc_pkg::REG_MIN_RUN:  min_run = val[ipc_pkg::TIMER_W-1:0];
        ipc_pkg::REG_MAX_RUN:  max_run = val[ipc_pkg::TIMER_W-1:0];
        ipc_pkg::REG_COOLDOWN: cool    = val[ipc_pkg::TIMER_W-1:0];
        default: ;
      endcase
    endfunction

    function void enter(input ipc_pkg::mode_e m);
      cur   = m;
      timer = '0;
    endfunction

    function void note_event(input logic [ipc_pkg::OP_W-1:0] op,
                             input logic [ipc_pkg::SAMPLE_W-1:0] s,
                             input logic water);
      pump_status_t st;
      logic         refused;
      refused = 1'b0;
      case (op)
        ipc_pkg::OP_SAMPLE: begin
          // ring is full: oldest sample drops out of the sum
          if (fill >= ipc_pkg::WINDOW_DEF) sum -= ring[slot];
          else fill++;
          ring[slot] = s;
          sum += s;
          slot = (slot + 1) % ipc_pkg::WINDOW_DEF;
          avg = ipc_pkg::SAMPLE_W'(sum / fill);
          if (timer != '1) timer++;
          case (cur)
            ipc_pkg::MODE_IDLE: begin
              if (avg <= dry && water) enter(ipc_pkg::MODE_WATERING);
            end
            ipc_pkg::MODE_WATERING: begin
              if (!water || timer >= max_run || (avg >= wet && timer >= min_run))
                enter(ipc_pkg::MODE_COOLDOWN);
            end
            ipc_pkg::MODE_COOLDOWN: begin
              if (timer >= cool) enter(ipc_pkg::MODE_IDLE);
            end
            default: enter(ipc_pkg::MODE_IDLE);
          endcase
        end
        ipc_pkg::OP_START: begin
          if (cur == ipc_pkg::MODE_IDLE && water) enter(ipc_pkg::MODE_WATERING);
          else refused = 1'b1;
        end
        ipc_pkg::OP_STOP: enter(ipc_pkg::MODE_COOLDOWN);
        default: ;
      endcase
      st.pump_on = (cur == ipc_pkg::MODE_WATERING);
      st.mode    = cur;
      st.avg     = avg;
      st.refused = refused;
      expected_status.push_back(st);
    endfunction

    // empty string when the status matches the oldest expectation
    function string check_status(input logic p, input logic [1:0] m,
                                 input logic [ipc_pkg::SAMPLE_W-1:0] a, input logic r);
      pump_status_t e;
      if (expected_status.size() == 0)
        return $sformatf("status with nothing awaited: pump %0b mode %0d avg %0d refused %0b",
                         p, m, a, r);
      e = expected_status.pop_front();
      if (p !== e.pump_on || m !== e.mode || a !== e.avg || r !== e.refused)
        return $sformatf("pump %0b/%0b mode %0d/%0d avg %0d/%0d refused %0b/%0b (got/exp)",
                         p, e.pump_on, m, e.mode, a, e.avg, r, e.refused);
      return "";
    endfunction

    function int awaited();
      return expected_status.size();
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [ipc_pkg::ADDR_W-1:0]   paddr;
  logic [ipc_pkg::DATA_W-1:0]   pwdata;
  logic [ipc_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [ipc_pkg::OP_W-1:0]     operation_i;
  logic [ipc_pkg::SAMPLE_W-1:0] soil_sample_i;
  logic                         tank_water_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic                         pump_on_o;
  logic [1:0]                   mode_o;
  logic [ipc_pkg::SAMPLE_W-1:0] moisture_average_o;
  logic                         start_refused_o;

  pump_mode_tracker tracker = new();
  int               mismatches = 0;
  int               quiet_cycles = 0;
  bit               hold_req = 1'b0;
  int               soil_level = 500;
  int               trend = 1;

  irrigation_pump_controller u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .soil_sample_i      (soil_sample_i),
    .tank_water_i       (tank_water_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .pump_on_o          (pump_on_o),
    .mode_o             (mode_o),
    .moisture_average_o (moisture_average_o),
    .start_refused_o    (start_refused_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    mismatches++;
    // keep the log short on a badly broken build
    if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Both channels are sampled here, at the edge, so every transfer is seen
  // with the values that were in effect before it. Results are checked before
  // the new input is noted; a result can never belong to an event that
  // transfers at the same edge.
  always @(posedge clk_i) begin : transfer_monitor
    string msg;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        msg = tracker.check_status(pump_on_o, mode_o, moisture_average_o, start_refused_o);
        if (msg != "") report_mismatch(msg);
      end
      if (in_valid_i && !in_stall_o)
        tracker.note_event(operation_i, soil_sample_i, tank_water_i);
    end
  end

  // Hang detector: any cycle with a transfer on either side resets the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver stall pattern: stretches of no stall, light, half and heavy
  // stalling, plus one long hold-off on request.
  initial begin : rx_stall_gen
    int left;
    int style;
    int hold_left;
    left        = 0;
    style       = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (left == 0) begin
          style = $urandom_range(0, 3);
          left  = $urandom_range(5, 120);
        end
        left--;
        case (style)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // APB write: setup cycle, then access until pready. Predictor follows.
  task automatic program_reg(input logic [ipc_pkg::REG_IDX_W-1:0] idx,
                             input logic [15:0] val);
    logic [ipc_pkg::DATA_W-1:0] word;
    // junk above the register width must be dropped by the block
    word        = $urandom();
    word[15:0]  = val;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.write_reg(idx, word);
  endtask

  // Offer one event and hold it until the transfer edge.
  task automatic send_event(input logic [ipc_pkg::OP_W-1:0] op,
                            input logic [ipc_pkg::SAMPLE_W-1:0] s,
                            input logic w);
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    soil_sample_i <= s;
    tank_water_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Sender stops until every status is back, then lets the block go quiet.
  // One edge first, so the monitor has noted the last transfer.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.awaited() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic program_all(input logic [15:0] dry, input logic [15:0] wet,
                             input logic [15:0] min_run, input logic [15:0] max_run,
                             input logic [15:0] cool);
    program_reg(ipc_pkg::REG_DRY, dry);
    program_reg(ipc_pkg::REG_WET, wet);
    program_reg(ipc_pkg::REG_MIN_RUN, min_run);
    program_reg(ipc_pkg::REG_MAX_RUN, max_run);
    program_reg(ipc_pkg::REG_COOLDOWN, cool);
  endtask

  function automatic logic [ipc_pkg::TIMER_W-1:0] pick_ticks();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return ipc_pkg::TIMER_W'($urandom_range(1, 12));
      default: return ipc_pkg::TIMER_W'($urandom_range(0, 60));
    endcase
  endfunction

  function automatic logic [ipc_pkg::SAMPLE_W-1:0] pick_level();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return ipc_pkg::SAMPLE_W'(ipc_pkg::SAMPLE_MAX);
      2:       return ipc_pkg::SAMPLE_W'($urandom_range(400, 600));
      default: return ipc_pkg::SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic [ipc_pkg::SAMPLE_W-1:0] clamp_sample(input int v);
    if (v < 0) return '0;
    if (v > ipc_pkg::SAMPLE_MAX) return ipc_pkg::SAMPLE_W'(ipc_pkg::SAMPLE_MAX);
    return ipc_pkg::SAMPLE_W'(v);
  endfunction

  initial begin : stimulus
    logic [ipc_pkg::OP_W-1:0]     op;
    logic [ipc_pkg::SAMPLE_W-1:0] s;
    logic                         w;
    int                           r;
    int                           burst_left;
    int                           gap;
    in_valid_i    = 1'b0;
    operation_i   = ipc_pkg::OP_SAMPLE;
    soil_sample_i = '0;
    tank_water_i  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rst_ni        = 1'b0;
    burst_left    = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed, reset thresholds ---
    send_event(OP_UNUSED, ipc_pkg::SAMPLE_W'(ipc_pkg::SAMPLE_MAX), 1'b1); // ignored
    send_event(ipc_pkg::OP_START, '0, 1'b0);            // no water: refused
    send_event(ipc_pkg::OP_SAMPLE, ipc_pkg::SAMPLE_W'(ipc_pkg::SAMPLE_MAX), 1'b1); // wet
    send_event(ipc_pkg::OP_STOP, '0, 1'b1);             // stop from idle
    send_event(ipc_pkg::OP_START, '0, 1'b1);            // refused in cooldown
    send_event(ipc_pkg::OP_SAMPLE, '0, 1'b1);           // average of two samples
    send_event(ipc_pkg::OP_STOP, ipc_pkg::SAMPLE_W'(ipc_pkg::SAMPLE_MAX), 1'b0);
    send_event(OP_UNUSED, '0, 1'b0);

    // --- directed, loose thresholds, zero min run and cooldown ---
    settle();
    program_all(16'h03FF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    program_reg(REG_UNUSED, 16'hFFFF);                  // dropped write
    send_event(ipc_pkg::OP_SAMPLE, '0, 1'b1);           // cooldown -> idle
    send_event(ipc_pkg::OP_SAMPLE, '0, 1'b1);           // idle dry -> watering
    send_event(ipc_pkg::OP_SAMPLE, ipc_pkg::SAMPLE_W'(ipc_pkg::SAMPLE_MAX), 1'b1); // -> cooldown
    send_event(ipc_pkg::OP_SAMPLE, 10'd500, 1'b1);      // cooldown -> idle
    send_event(ipc_pkg::OP_SAMPLE, 10'd500, 1'b0);      // dry but tank empty
    send_event(ipc_pkg::OP_START, '0, 1'b1);            // honored
    send_event(ipc_pkg::OP_START, '0, 1'b1);            // refused while watering
    send_event(ipc_pkg::OP_SAMPLE, 10'd700, 1'b0);      // tank empty -> cooldown

    // --- directed, tight thresholds, max run zero ---
    settle();
    program_all(16'h0000, 16'h03FF, 16'hFFFF, 16'h0000, 16'h0000);
    send_event(ipc_pkg::OP_SAMPLE, '0, 1'b1);           // cooldown -> idle
    send_event(ipc_pkg::OP_START, ipc_pkg::SAMPLE_W'(ipc_pkg::SAMPLE_MAX), 1'b1); // honored
    send_event(ipc_pkg::OP_SAMPLE, ipc_pkg::SAMPLE_W'(ipc_pkg::SAMPLE_MAX), 1'b1); // max run
    send_event(ipc_pkg::OP_SAMPLE, '0, 1'b1);           // -> idle
    send_event(ipc_pkg::OP_SAMPLE, '0, 1'b1);           // average above zero, stays idle
    send_event(ipc_pkg::OP_STOP, '0, 1'b1);

    // --- random phases ---
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: program_all(16'h03FF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        1: program_all(16'h0000, 16'h03FF, 16'hFFFF, 16'hFFFF, 16'h0000);
        default: program_all(16'(pick_level()), 16'(pick_level()), pick_ticks(),
                             pick_ticks(), pick_ticks());
      endcase
      // one phase backs the block up: long receiver hold, sender keeps offering
      if (ph == 3) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (!(ph == 3 && n < 60)) begin
          if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
              in_valid_i <= 1'b0;
              repeat (gap) @(posedge clk_i);
            end
          end
          burst_left--;
        end

        r = $urandom_range(0, 99);
        if (r < 72) op = ipc_pkg::OP_SAMPLE;
        else if (r < 84) op = ipc_pkg::OP_START;
        else if (r < 93) op = ipc_pkg::OP_STOP;
        else op = OP_UNUSED;
        w = ($urandom_range(0, 99) < 88);

        // soil drifts between wet and dry so the mode machine keeps cycling
        if (soil_level <= 0) trend = 1;
        else if (soil_level >= ipc_pkg::SAMPLE_MAX) trend = -1;
        else if ($urandom_range(0, 39) == 0) trend = -trend;
        soil_level += trend * int'($urandom_range(0, 25));
        if (soil_level < 0) soil_level = 0;
        if (soil_level > ipc_pkg::SAMPLE_MAX) soil_level = ipc_pkg::SAMPLE_MAX;

        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: s = clamp_sample(soil_level + int'($urandom_range(0, 30)) - 15);
          5, 6:          s = ipc_pkg::SAMPLE_W'($urandom());
          7:             s = $urandom_range(0, 1) ?
                             ipc_pkg::SAMPLE_W'(ipc_pkg::SAMPLE_MAX) : '0;
          8:             s = clamp_sample(int'(tracker.dry) + int'($urandom_range(0, 6)) - 3);
          default:       s = clamp_sample(int'(tracker.wet) + int'($urandom_range(0, 6)) - 3);
        endcase
        send_event(op, s, w);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.awaited() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: irrigation_pump_controller.f
+incdir+hdl
hdl/ipc_pkg.sv
hdl/ipc_cfg.sv
hdl/ipc_ctrl.sv
hdl/ipc_datapath.sv
hdl/irrigation_pump_controller.sv
hdl/ipc_checker.sv
tb/irrigation_pump_controller_tb.sv
